>>> rtl/sakf_pkg.sv
// Shared types and constants for the scalar adaptive Kalman filter unit.
package sakf_pkg;

	localparam int SampleW  = 16;
	localparam int EstW     = 32;
	localparam int ErrW     = 32;
	localparam int MeasW    = 31;
	localparam int SpeedW   = 17;
	localparam int GainW    = 17;
	localparam int DenW     = 33;
	localparam int MagW     = 33;
	localparam int ProdW    = MagW + GainW;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 31;
	localparam int CntW     = 5;

	localparam logic [GainW-1:0]  ONE_Q16       = 17'd65536;
	localparam logic [MeasW-1:0]  MEAS_RESET    = 31'd65536;
	localparam logic [SpeedW-1:0] SPEED_RESET   = 17'd6554;
	localparam logic [CntW-1:0]   DIV_LAST_STEP = 5'd16;

	localparam logic [CfgIdxW-1:0] REG_ERR_MEASURE = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_SPEED       = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_DELTA,
		ST_MUL_KEEP,
		ST_MUL_SPEED,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_DELTA,
		MUL_KEEP,
		MUL_SPEED
	} mul_sel_t;

	typedef struct packed {
		logic     start;
		logic     div_step;
		mul_sel_t mul_sel;
		logic     commit;
	} cmd_t;

endpackage

>>> rtl/scalar_adaptive_kalman_filter_unit.sv
// Scalar adaptive Kalman filter unit: top level joining controller and datapath.
//
// Input channel: sample (signed 16-bit) with in_valid / in_stall. An item is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: estimate (signed Q16.16) with out_valid / out_stall, one
// result item per input item, in order.
// Config port: cfg_we, cfg_index, cfg_data. Index 0 is err_measure (Q15.16),
// index 1 is speed (Q1.16). Any write clears the estimate to zero and sets the
// estimate error to err_measure. Write only while the unit is idle.
// The unit runs the 17 steps of the gain divider, three passes through the
// shared multiplier and a commit for each item, and takes no new item until
// the previous one has been committed.
// A finished estimate sits in the output register; the next item is taken
// while it waits. If it is still stalled when the next result is ready, the
// unit holds that result in the commit state until the output frees up.
// Reset (arst_n low) restores err_measure 1.0, speed 6554, estimate zero and
// estimate error 1.0, and empties the output.
module scalar_adaptive_kalman_filter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sakf_pkg::SampleW-1:0] sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sakf_pkg::EstW-1:0]    estimate,
	input  logic                                cfg_we,
	input  logic [sakf_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [sakf_pkg::CfgDataW-1:0]       cfg_data
);

	sakf_pkg::cmd_t cmd;

	sakf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sakf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.estimate  (estimate)
	);

endmodule

>>> rtl/sakf_ctrl.sv
// Sequencer for the filter step: divider iterations, multiplies, result handoff.
module sakf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output sakf_pkg::cmd_t    cmd
);

	sakf_pkg::state_t                state_q, state_d;
	logic [sakf_pkg::CntW-1:0]       cnt_q, cnt_d;
	logic                            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sakf_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		out_valid_d  = out_valid_q & out_stall;
		cmd.start    = 1'b0;
		cmd.div_step = 1'b0;
		cmd.mul_sel  = sakf_pkg::MUL_NONE;
		cmd.commit   = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			sakf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					cnt_d     = sakf_pkg::DIV_LAST_STEP;
					state_d   = sakf_pkg::ST_DIV;
				end
			end
			sakf_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = sakf_pkg::ST_MUL_DELTA;
				end
			end
			sakf_pkg::ST_MUL_DELTA: begin
				cmd.mul_sel = sakf_pkg::MUL_DELTA;
				state_d     = sakf_pkg::ST_MUL_KEEP;
			end
			sakf_pkg::ST_MUL_KEEP: begin
				cmd.mul_sel = sakf_pkg::MUL_KEEP;
				state_d     = sakf_pkg::ST_MUL_SPEED;
			end
			sakf_pkg::ST_MUL_SPEED: begin
				cmd.mul_sel = sakf_pkg::MUL_SPEED;
				state_d     = sakf_pkg::ST_DONE;
			end
			sakf_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = sakf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sakf_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/sakf_datapath.sv
// Filter datapath: config registers, filter state, restoring divider, shared multiplier.
module sakf_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sakf_pkg::cmd_t                      cmd,
	input  logic                                cfg_we,
	input  logic [sakf_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [sakf_pkg::CfgDataW-1:0]       cfg_data,
	input  logic signed [sakf_pkg::SampleW-1:0] sample,
	output logic signed [sakf_pkg::EstW-1:0]    estimate
);

	logic [sakf_pkg::MeasW-1:0]   meas_q;
	logic [sakf_pkg::SpeedW-1:0]  speed_q;
	logic [sakf_pkg::EstW-1:0]    x_q;
	logic [sakf_pkg::ErrW-1:0]    e_q;

	logic [sakf_pkg::DenW-1:0]    den_q;
	logic                         den_zero_q;
	logic [sakf_pkg::DenW-1:0]    rem_q;
	logic [sakf_pkg::GainW-1:0]   num_q;
	logic [sakf_pkg::GainW-1:0]   quo_q;
	logic [sakf_pkg::MagW-1:0]    mag_q;
	logic                         neg_q;
	logic [sakf_pkg::MagW-1:0]    dmag_q;
	logic [sakf_pkg::ErrW-1:0]    t1_q;
	logic [sakf_pkg::ProdW-17:0]  t2_q;
	logic [sakf_pkg::EstW-1:0]    est_q;

	logic [sakf_pkg::DenW-1:0]    den_d;
	logic [sakf_pkg::MagW-1:0]    diff_d;
	logic [sakf_pkg::DenW:0]      trial;
	logic                         fits;
	logic [sakf_pkg::GainW-1:0]   gain;
	logic [sakf_pkg::MagW-1:0]    mul_a;
	logic [sakf_pkg::GainW-1:0]   mul_b;
	logic [sakf_pkg::ProdW-1:0]   prod;
	logic [sakf_pkg::MagW:0]      delta;
	logic [sakf_pkg::MagW:0]      x_sum;
	logic [sakf_pkg::EstW-1:0]    x_new;
	logic [sakf_pkg::ProdW-15:0]  e_sum;
	logic [sakf_pkg::ErrW-1:0]    e_new;

	assign den_d  = {1'b0, e_q} + {2'b0, meas_q};
	assign diff_d = {sample[sakf_pkg::SampleW-1], sample, 16'b0} - {x_q[sakf_pkg::EstW-1], x_q};
	assign trial  = {rem_q, num_q[sakf_pkg::GainW-1]};
	assign fits   = trial >= {1'b0, den_q};
	assign gain   = den_zero_q ? '0 : quo_q;

	always_comb begin
		case (cmd.mul_sel)
			sakf_pkg::MUL_DELTA: begin
				mul_a = mag_q;
				mul_b = gain;
			end
			sakf_pkg::MUL_KEEP: begin
				mul_a = {1'b0, e_q};
				mul_b = sakf_pkg::ONE_Q16 - gain;
			end
			sakf_pkg::MUL_SPEED: begin
				mul_a = dmag_q;
				mul_b = speed_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign delta = neg_q ? -{1'b0, dmag_q} : {1'b0, dmag_q};
	assign x_sum = {{2{x_q[sakf_pkg::EstW-1]}}, x_q} + delta;
	assign x_new = x_sum[sakf_pkg::EstW-1:0];
	assign e_sum = {4'b0, t1_q} + {2'b0, t2_q};
	assign e_new = (e_sum[sakf_pkg::ProdW-15:sakf_pkg::ErrW] != '0) ? '1
		: e_sum[sakf_pkg::ErrW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meas_q  <= sakf_pkg::MEAS_RESET;
			speed_q <= sakf_pkg::SPEED_RESET;
			x_q     <= '0;
			e_q     <= {1'b0, sakf_pkg::MEAS_RESET};
		end else if (cfg_we) begin
			x_q <= '0;
			case (cfg_index)
				sakf_pkg::REG_ERR_MEASURE: begin
					meas_q <= cfg_data;
					e_q    <= {1'b0, cfg_data};
				end
				sakf_pkg::REG_SPEED: begin
					speed_q <= cfg_data[sakf_pkg::SpeedW-1:0];
					e_q     <= {1'b0, meas_q};
				end
				default: begin
					e_q <= {1'b0, meas_q};
				end
			endcase
		end else if (cmd.commit) begin
			x_q <= x_new;
			e_q <= e_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			den_q      <= den_d;
			den_zero_q <= den_d == '0;
			rem_q      <= {2'b0, e_q[sakf_pkg::ErrW-1:1]};
			num_q      <= {e_q[0], 16'b0};
			quo_q      <= '0;
			neg_q      <= diff_d[sakf_pkg::MagW-1];
			mag_q      <= diff_d[sakf_pkg::MagW-1] ? -diff_d : diff_d;
		end
		if (cmd.div_step) begin
			rem_q <= fits ? trial[sakf_pkg::DenW-1:0] - den_q : trial[sakf_pkg::DenW-1:0];
			num_q <= {num_q[sakf_pkg::GainW-2:0], 1'b0};
			quo_q <= {quo_q[sakf_pkg::GainW-2:0], fits};
		end
		case (cmd.mul_sel)
			sakf_pkg::MUL_DELTA: dmag_q <= prod[sakf_pkg::MagW+15:16];
			sakf_pkg::MUL_KEEP:  t1_q   <= prod[sakf_pkg::ErrW+15:16];
			sakf_pkg::MUL_SPEED: t2_q   <= prod[sakf_pkg::ProdW-1:16];
			default: begin
			end
		endcase
		if (cmd.commit) begin
			est_q <= x_new;
		end
	end

	assign estimate = est_q;

endmodule

>>> verif/tb_scalar_adaptive_kalman_filter_unit.sv
// Self-checking testbench for the scalar adaptive Kalman filter unit.
module tb_scalar_adaptive_kalman_filter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 20000;
	localparam int PhaseItems = 150;
	localparam int Phases     = 12;

	// Tracks filter state and holds the estimates still owed by the unit.
	class estimate_tracker;
		logic [sakf_pkg::MeasW-1:0]        meas;
		logic [sakf_pkg::SpeedW-1:0]       spd;
		logic signed [sakf_pkg::EstW-1:0]  est;
		logic [sakf_pkg::ErrW-1:0]         err;
		logic signed [sakf_pkg::EstW-1:0]  pending_estimates[$];
		int unsigned                       mismatches;
		int unsigned                       checked;

		function new();
			meas = sakf_pkg::MEAS_RESET;
			spd = sakf_pkg::SPEED_RESET;
			mismatches = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			est = '0;
			err = {1'b0, meas};
		endfunction

		function void apply_reg(logic [sakf_pkg::CfgIdxW-1:0] idx,
			logic [sakf_pkg::CfgDataW-1:0] data);
			case (idx)
			sakf_pkg::REG_ERR_MEASURE: meas = data[sakf_pkg::MeasW-1:0];
			sakf_pkg::REG_SPEED: spd = data[sakf_pkg::SpeedW-1:0];
			default: return;
			endcase
			restart();
		endfunction

		function void take_sample(logic signed [sakf_pkg::SampleW-1:0] s);
			longint unsigned e, den, gain, mag, dmag, keep, drift, nxt;
			longint diff;
			e = {32'b0, err};
			den = e + {33'b0, meas};
			gain = (den != 0) ? (e << 16) / den : 0;
			diff = longint'(s) * 65536 - longint'(est);
			if (diff < 0)
				mag = -diff;
			else
				mag = diff;
			dmag = (mag * gain) >> 16;
			if (diff < 0)
				est = est - dmag[sakf_pkg::EstW-1:0];
			else
				est = est + dmag[sakf_pkg::EstW-1:0];
			keep = ((sakf_pkg::ONE_Q16 - gain) * e) >> 16;
			drift = (dmag * spd) >> 16;
			nxt = keep + drift;
			if (nxt > 64'hFFFF_FFFF)
				nxt = 64'hFFFF_FFFF;
			err = nxt[sakf_pkg::ErrW-1:0];
			pending_estimates.push_back(est);
		endfunction

		function void check_estimate(logic signed [sakf_pkg::EstW-1:0] got);
			logic signed [sakf_pkg::EstW-1:0] want;
			checked++;
			if (pending_estimates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("estimate %0d arrived with no sample outstanding", got);
				return;
			end
			want = pending_estimates.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("estimate #%0d: expected %0d (0x%08h), got %0d (0x%08h)",
						checked, want, want, got, got);
			end
		endfunction
	endclass

	logic                                  clk;
	logic                                  arst_n = 1'b0;
	logic                                  in_valid = 1'b0;
	logic                                  in_stall;
	logic signed [sakf_pkg::SampleW-1:0]   sample = '0;
	logic                                  out_valid;
	logic                                  out_stall = 1'b0;
	logic signed [sakf_pkg::EstW-1:0]      estimate;
	logic                                  cfg_we = 1'b0;
	logic [sakf_pkg::CfgIdxW-1:0]          cfg_index = '0;
	logic [sakf_pkg::CfgDataW-1:0]         cfg_data = '0;

	estimate_tracker tracker = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int sensor_level = 0;
	int quiet_cycles = 0;
	int n_samples = 0;
	int n_writes = 0;

	scalar_adaptive_kalman_filter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.estimate(estimate),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				tracker.apply_reg(cfg_index, cfg_data);
				n_writes++;
			end
			if (in_valid && !in_stall) begin
				tracker.take_sample(sample);
				n_samples++;
			end
			if (out_valid && !out_stall) begin
				tracker.check_estimate(estimate);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("watchdog: no item moved for %0d cycles", quiet_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
		1: begin
			send_idle_pct = 76;
			recv_stall_pct = 0;
		end
		2: begin
			send_idle_pct = 0;
			recv_stall_pct = 76;
		end
		3: begin
			send_idle_pct = 31;
			recv_stall_pct = 31;
		end
		default: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		endcase
	endtask

	task automatic send_sample(input logic signed [sakf_pkg::SampleW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_estimates.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_reg(input logic [sakf_pkg::CfgIdxW-1:0] idx,
		input logic [sakf_pkg::CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic pick_setting();
		logic [sakf_pkg::CfgDataW-1:0] m, sp;
		int which;
		case ($urandom_range(9))
		0, 1: m = 31'($urandom_range(16, 1));
		2, 3, 4: m = 31'($urandom_range(1 << 20, 1 << 12));
		5, 6: m = 31'($urandom);
		7: m = 31'h7FFF_FFFF;
		8: m = sakf_pkg::MEAS_RESET;
		default: m = '0;
		endcase
		case ($urandom_range(5))
		0: sp = '0;
		1: sp = {14'b0, sakf_pkg::ONE_Q16};
		2: sp = 31'($urandom_range(65536));
		3: sp = 31'($urandom_range(131071, 65537));
		default: sp = 31'($urandom_range(8191));
		endcase
		sp = (31'($urandom) & ~31'h1FFFF) | sp;
		which = int'($urandom_range(2));
		if (which != 1)
			load_reg(sakf_pkg::REG_ERR_MEASURE, m);
		if (which != 0)
			load_reg(sakf_pkg::REG_SPEED, sp);
	endtask

	function automatic logic signed [sakf_pkg::SampleW-1:0] next_sample();
		int pick, v, amp;
		pick = $urandom_range(99);
		if (pick < 12) begin
			case ($urandom_range(3))
			0: v = 32767;
			1: v = -32768;
			2: v = 0;
			default: v = -1;
			endcase
		end else if (pick < 37) begin
			v = int'($urandom_range(65535)) - 32768;
		end else begin
			if ($urandom_range(15) == 0)
				sensor_level = int'($urandom_range(65535)) - 32768;
			sensor_level += int'($urandom_range(64)) - 32;
			if (sensor_level > 32767)
				sensor_level = 32767;
			if (sensor_level < -32768)
				sensor_level = -32768;
			amp = 1 << $urandom_range(10);
			v = sensor_level + int'($urandom_range(2 * amp)) - amp;
		end
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[sakf_pkg::SampleW-1:0];
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, full-scale swings
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		send_sample(16'sd0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(-16'sd32768);
		send_sample(-16'sd32768);
		drain();

		// zero measurement error: gain stays zero, estimate holds
		load_reg(sakf_pkg::REG_ERR_MEASURE, '0);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd5);
		drain();

		// largest error and speed above one, error sum saturates
		load_reg(sakf_pkg::REG_ERR_MEASURE, 31'h7FFF_FFFF);
		load_reg(sakf_pkg::REG_SPEED, 31'h7FFF_FFFF);
		for (int i = 0; i < 3; i++) begin
			send_sample(16'sd32767);
			send_sample(-16'sd32768);
		end
		drain();

		load_reg(sakf_pkg::REG_ERR_MEASURE, 31'd1);
		load_reg(sakf_pkg::REG_SPEED, '0);
		send_sample(16'sd32767);
		send_sample(-16'sd32768);
		send_sample(16'sd100);
		send_sample(16'sd100);
		drain();

		load_reg(sakf_pkg::REG_SPEED, {14'b0, sakf_pkg::ONE_Q16});
		send_sample(-16'sd32768);
		send_sample(16'sd32767);
		drain();

		for (int k = 0; k < Phases; k++) begin
			pick_setting();
			set_idling(0);
			for (int i = 0; i < PhaseItems; i++) begin
				if (i == 30)
					set_idling(k % 4);
				send_sample(next_sample());
			end
			drain();
		end

		set_idling(0);
		repeat (40) @(posedge clk);
		$display("Covered %0d samples, %0d estimates checked, %0d register writes",
			n_samples, tracker.checked, n_writes);
		$display("Settings ranged over zero, minimum and maximum measurement error and speed 0..2.0");
		if (tracker.mismatches == 0 && tracker.pending_estimates.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/sakf_pkg.sv
rtl/sakf_ctrl.sv
rtl/sakf_datapath.sv
rtl/scalar_adaptive_kalman_filter_unit.sv
verif/tb_scalar_adaptive_kalman_filter_unit.sv
